/* rtl/ccs_pkg.sv */
// ============================================================================
// ccs_pkg
// Types, codes and calendar helpers shared by the calendar clock stepper.
// ============================================================================
package ccs_pkg;

    localparam logic [4:0]  DAY_MIN  = 5'd1;
    localparam logic [3:0]  MON_MIN  = 4'd1;
    localparam logic [3:0]  MON_MAX  = 4'd12;
    localparam logic [13:0] YEAR_MIN = 14'd1;
    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [4:0]  HOUR_MAX = 5'd23;
    localparam logic [5:0]  MIN_MAX  = 6'd59;
    localparam logic [5:0]  SEC_MAX  = 6'd59;

    // multiplicative inverse of 25 modulo 2^14 and the divisibility bound
    localparam logic [13:0] INV25   = 14'd7209;
    localparam logic [13:0] DIV25_LIM = 14'd655;

    typedef enum logic [3:0] {
        REQ_UP_SEC   = 4'd0,
        REQ_UP_MIN   = 4'd1,
        REQ_UP_HOUR  = 4'd2,
        REQ_UP_DAY   = 4'd3,
        REQ_UP_MON   = 4'd4,
        REQ_UP_YEAR  = 4'd5,
        REQ_DN_SEC   = 4'd6,
        REQ_DN_MIN   = 4'd7,
        REQ_DN_HOUR  = 4'd8,
        REQ_DN_DAY   = 4'd9,
        REQ_DN_MON   = 4'd10,
        REQ_DN_YEAR  = 4'd11,
        REQ_LOAD     = 4'd12
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_SAT    = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    typedef struct packed {
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } ccs_time_t;

    typedef struct packed {
        logic [3:0] kind;
        ccs_time_t  load;
    } ccs_req_t;

    function automatic logic is_leap(input logic [13:0] y);
        logic [13:0] p;
        logic        div25;
        p     = y * INV25;
        div25 = (p <= DIV25_LIM);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* rtl/ccs_step.sv */
// ============================================================================
// ccs_step
// Next date and time and status for one request, from the current state.
// ============================================================================
module ccs_step
(
    input  ccs_pkg::ccs_time_t cur,
    input  ccs_pkg::ccs_req_t  req,
    output ccs_pkg::ccs_time_t nxt,
    output ccs_pkg::status_t   status
);

    logic               leap_cur;
    logic               leap_up;
    logic               leap_dn;
    logic               leap_ld;
    logic [13:0]        year_up;
    logic [13:0]        year_dn;
    logic [4:0]         len_cur;
    logic [4:0]         len_ld;
    logic [3:0]         mon_dn;

    ccs_pkg::ccs_time_t t;
    ccs_pkg::req_t      kind;
    logic               sat;
    logic               bad;
    logic               up;
    logic               dn;
    logic               c;
    logic [1:0]         lvl;
    logic [4:0]         clamp_len;

    assign year_up  = cur.year + 14'd1;
    assign year_dn  = cur.year - 14'd1;
    assign mon_dn   = cur.month - 4'd1;
    assign leap_cur = ccs_pkg::is_leap(cur.year);
    assign leap_up  = ccs_pkg::is_leap(year_up);
    assign leap_dn  = ccs_pkg::is_leap(year_dn);
    assign leap_ld  = ccs_pkg::is_leap(req.load.year);
    assign len_cur  = ccs_pkg::month_len(cur.month, leap_cur);
    assign len_ld   = ccs_pkg::month_len(req.load.month, leap_ld);
    assign kind     = ccs_pkg::req_t'(req.kind);

    always_comb
    begin
        t         = cur;
        sat       = 1'b0;
        bad       = 1'b0;
        up        = 1'b0;
        dn        = 1'b0;
        lvl       = 2'd0;
        c         = 1'b1;
        clamp_len = 5'd31;

        unique case (kind)
            ccs_pkg::REQ_UP_SEC:  begin up = 1'b1; lvl = 2'd0; end
            ccs_pkg::REQ_UP_MIN:  begin up = 1'b1; lvl = 2'd1; end
            ccs_pkg::REQ_UP_HOUR: begin up = 1'b1; lvl = 2'd2; end
            ccs_pkg::REQ_UP_DAY:  begin up = 1'b1; lvl = 2'd3; end
            ccs_pkg::REQ_DN_SEC:  begin dn = 1'b1; lvl = 2'd0; end
            ccs_pkg::REQ_DN_MIN:  begin dn = 1'b1; lvl = 2'd1; end
            ccs_pkg::REQ_DN_HOUR: begin dn = 1'b1; lvl = 2'd2; end
            ccs_pkg::REQ_DN_DAY:  begin dn = 1'b1; lvl = 2'd3; end
            ccs_pkg::REQ_UP_MON:
            begin
                if (cur.month < ccs_pkg::MON_MAX)
                begin
                    t.month = cur.month + 4'd1;
                end
                else if (cur.year >= ccs_pkg::YEAR_MAX)
                begin
                    sat = 1'b1;
                end
                else
                begin
                    t.month = ccs_pkg::MON_MIN;
                    t.year  = year_up;
                end
                clamp_len = ccs_pkg::month_len(t.month, leap_cur);
            end
            ccs_pkg::REQ_DN_MON:
            begin
                if (cur.month > ccs_pkg::MON_MIN)
                begin
                    t.month = mon_dn;
                end
                else if (cur.year <= ccs_pkg::YEAR_MIN)
                begin
                    sat = 1'b1;
                end
                else
                begin
                    t.month = ccs_pkg::MON_MAX;
                    t.year  = year_dn;
                end
                clamp_len = ccs_pkg::month_len(t.month, leap_cur);
            end
            ccs_pkg::REQ_UP_YEAR:
            begin
                if (cur.year >= ccs_pkg::YEAR_MAX)
                begin
                    sat = 1'b1;
                end
                else
                begin
                    t.year = year_up;
                end
                clamp_len = ccs_pkg::month_len(cur.month, leap_up);
            end
            ccs_pkg::REQ_DN_YEAR:
            begin
                if (cur.year <= ccs_pkg::YEAR_MIN)
                begin
                    sat = 1'b1;
                end
                else
                begin
                    t.year = year_dn;
                end
                clamp_len = ccs_pkg::month_len(cur.month, leap_dn);
            end
            ccs_pkg::REQ_LOAD:
            begin
                bad = (req.load.month < ccs_pkg::MON_MIN) || (req.load.month > ccs_pkg::MON_MAX)
                   || (req.load.year < ccs_pkg::YEAR_MIN) || (req.load.year > ccs_pkg::YEAR_MAX)
                   || (req.load.day < ccs_pkg::DAY_MIN) || (req.load.day > len_ld)
                   || (req.load.hours > ccs_pkg::HOUR_MAX)
                   || (req.load.minutes > ccs_pkg::MIN_MAX)
                   || (req.load.seconds > ccs_pkg::SEC_MAX);
                t = req.load;
            end
            default:
            begin
            end
        endcase

        if (t.day > clamp_len)
        begin
            t.day = clamp_len;
        end

        // carry chain upward from the requested unit
        if (up)
        begin
            if (lvl == 2'd0)
            begin
                if (cur.seconds == ccs_pkg::SEC_MAX) t.seconds = 6'd0;
                else begin t.seconds = cur.seconds + 6'd1; c = 1'b0; end
            end
            if (lvl <= 2'd1 && c)
            begin
                if (cur.minutes == ccs_pkg::MIN_MAX) t.minutes = 6'd0;
                else begin t.minutes = cur.minutes + 6'd1; c = 1'b0; end
            end
            if (lvl <= 2'd2 && c)
            begin
                if (cur.hours == ccs_pkg::HOUR_MAX) t.hours = 5'd0;
                else begin t.hours = cur.hours + 5'd1; c = 1'b0; end
            end
            if (c)
            begin
                if (cur.day >= len_cur) t.day = ccs_pkg::DAY_MIN;
                else begin t.day = cur.day + 5'd1; c = 1'b0; end
            end
            if (c)
            begin
                if (cur.month >= ccs_pkg::MON_MAX) t.month = ccs_pkg::MON_MIN;
                else begin t.month = cur.month + 4'd1; c = 1'b0; end
            end
            if (c)
            begin
                if (cur.year >= ccs_pkg::YEAR_MAX) sat = 1'b1;
                else t.year = year_up;
            end
        end

        // borrow chain downward from the requested unit
        if (dn)
        begin
            if (lvl == 2'd0)
            begin
                if (cur.seconds == 6'd0) t.seconds = ccs_pkg::SEC_MAX;
                else begin t.seconds = cur.seconds - 6'd1; c = 1'b0; end
            end
            if (lvl <= 2'd1 && c)
            begin
                if (cur.minutes == 6'd0) t.minutes = ccs_pkg::MIN_MAX;
                else begin t.minutes = cur.minutes - 6'd1; c = 1'b0; end
            end
            if (lvl <= 2'd2 && c)
            begin
                if (cur.hours == 5'd0) t.hours = ccs_pkg::HOUR_MAX;
                else begin t.hours = cur.hours - 5'd1; c = 1'b0; end
            end
            if (c)
            begin
                if (cur.day > ccs_pkg::DAY_MIN)
                begin
                    t.day = cur.day - 5'd1;
                end
                else if (cur.month > ccs_pkg::MON_MIN)
                begin
                    t.month = mon_dn;
                    t.day   = ccs_pkg::month_len(mon_dn, leap_cur);
                end
                else if (cur.year <= ccs_pkg::YEAR_MIN)
                begin
                    sat = 1'b1;
                end
                else
                begin
                    t.month = ccs_pkg::MON_MAX;
                    t.year  = year_dn;
                    t.day   = ccs_pkg::month_len(ccs_pkg::MON_MAX, leap_dn);
                end
            end
        end
    end

    always_comb
    begin
        priority if (sat)
        begin
            status = ccs_pkg::ST_SAT;
            nxt    = cur;
        end
        else if (bad)
        begin
            status = ccs_pkg::ST_REJECT;
            nxt    = cur;
        end
        else
        begin
            status = ccs_pkg::ST_DONE;
            nxt    = t;
        end
    end

endmodule

/* rtl/calendar_clock_stepper.sv */
// ============================================================================
// calendar_clock_stepper
// Gregorian date and time of day, loaded or stepped one unit per request.
// ============================================================================
// slave stream: one beat is one request; s_tuser carries the request code
// (step up or down by second, minute, hour, day, month or year, or load),
// s_tdata the date and time used by a load
// master stream: one beat per request with the date and time after it and
// a status code in m_tuser (done, saturated at a calendar limit, load
// rejected); a saturated or rejected request leaves the state unchanged
// a request goes into an input register; the step logic updates the
// calendar state and the result register together whenever the result
// register is empty or being taken, and the result beat is then valid
// throughput is one request per cycle while the receiver is ready, set by the
// combinational step logic that reads and writes the calendar state registers
// reset sets 1000-01-01 00:00:00 and empties both registers
// when the receiver stalls, the waiting result holds and one more request
// can still be taken into the input register; then s_tready drops
// ============================================================================
module calendar_clock_stepper
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // load_day, load_month, load_year, load_hours, load_minutes, load_seconds
    input  logic [39:0] s_tdata,
    // req_type
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_day, out_month, out_year, out_hours, out_minutes, out_seconds
    output logic [39:0] m_tdata,
    // status
    output logic [1:0]  m_tuser
);

    logic               in_valid_reg;
    ccs_pkg::ccs_req_t  in_req_reg;
    logic               out_valid_reg;
    ccs_pkg::ccs_time_t out_time_reg;
    ccs_pkg::status_t   out_status_reg;
    ccs_pkg::ccs_time_t cur_reg;
    ccs_pkg::ccs_time_t cur_next;
    ccs_pkg::status_t   step_status;
    logic               advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    ccs_step u_step
    (
        .cur    (cur_reg),
        .req    (in_req_reg),
        .nxt    (cur_next),
        .status (step_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            cur_reg.day     <= 5'd1;
            cur_reg.month   <= 4'd1;
            cur_reg.year    <= 14'd1000;
            cur_reg.hours   <= 5'd0;
            cur_reg.minutes <= 6'd0;
            cur_reg.seconds <= 6'd0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    cur_reg <= cur_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg.kind         <= s_tuser;
            in_req_reg.load.day     <= s_tdata[4:0];
            in_req_reg.load.month   <= s_tdata[8:5];
            in_req_reg.load.year    <= s_tdata[22:9];
            in_req_reg.load.hours   <= s_tdata[27:23];
            in_req_reg.load.minutes <= s_tdata[33:28];
            in_req_reg.load.seconds <= s_tdata[39:34];
        end
        if (advance && in_valid_reg)
        begin
            out_time_reg   <= cur_next;
            out_status_reg <= step_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_time_reg.seconds, out_time_reg.minutes, out_time_reg.hours,
                       out_time_reg.year, out_time_reg.month, out_time_reg.day};
    assign m_tuser  = out_status_reg;

endmodule

/* dv/calendar_clock_stepper_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// calendar_clock_stepper_checker
// Watches both streams of the calendar clock stepper. It keeps its own copy
// of the calendar, predicts the date, time and status of every request beat,
// and compares each result beat field by field in order.
// ============================================================================
module calendar_clock_stepper_checker
    import ccs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        status_t   status;
        ccs_time_t moment;
    } outcome_t;

    ccs_time_t clock_now;
    outcome_t  outcome_q[$];

    function automatic bit leap_year(input logic [13:0] y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic logic [4:0] days_of(input logic [3:0] m, input logic [13:0] y);
        case (m)
            4'd2:                    return leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default:                 return 5'd31;
        endcase
    endfunction

    function automatic void fit_day(inout ccs_time_t t);
        logic [4:0] last;
        last = days_of(t.month, t.year);
        if (t.day > last)
            t.day = last;
    endfunction

    // returns 1 when the step would pass the upper calendar limit
    function automatic bit step_up(inout ccs_time_t t, input logic [3:0] kind);
        bit carry;
        carry = 1'b1;
        if (kind >= REQ_UP_MON)
        begin
            if (kind == REQ_UP_MON && t.month < MON_MAX)
                t.month = t.month + 4'd1;
            else if (t.year >= YEAR_MAX)
                return 1'b1;
            else
            begin
                if (kind == REQ_UP_MON)
                    t.month = MON_MIN;
                t.year = t.year + 14'd1;
            end
            fit_day(t);
            return 1'b0;
        end
        if (kind == REQ_UP_SEC)
        begin
            if (t.seconds < SEC_MAX)
            begin
                t.seconds = t.seconds + 6'd1;
                carry = 1'b0;
            end
            else
                t.seconds = '0;
        end
        if (carry && kind <= REQ_UP_MIN)
        begin
            if (t.minutes < MIN_MAX)
            begin
                t.minutes = t.minutes + 6'd1;
                carry = 1'b0;
            end
            else
                t.minutes = '0;
        end
        if (carry && kind <= REQ_UP_HOUR)
        begin
            if (t.hours < HOUR_MAX)
            begin
                t.hours = t.hours + 5'd1;
                carry = 1'b0;
            end
            else
                t.hours = '0;
        end
        if (carry && kind <= REQ_UP_DAY)
        begin
            if (t.day < days_of(t.month, t.year))
            begin
                t.day = t.day + 5'd1;
                carry = 1'b0;
            end
            else
            begin
                t.day = DAY_MIN;
                if (t.month < MON_MAX)
                begin
                    t.month = t.month + 4'd1;
                    carry = 1'b0;
                end
                else
                begin
                    t.month = MON_MIN;
                    t.year = t.year + 14'd1;
                end
            end
        end
        return carry && (t.year > YEAR_MAX);
    endfunction

    // returns 1 when the step would pass the lower calendar limit
    function automatic bit step_down(inout ccs_time_t t, input logic [3:0] kind);
        bit borrow;
        borrow = 1'b1;
        if (kind >= REQ_DN_MON)
        begin
            if (kind == REQ_DN_MON && t.month > MON_MIN)
                t.month = t.month - 4'd1;
            else if (t.year <= YEAR_MIN)
                return 1'b1;
            else
            begin
                if (kind == REQ_DN_MON)
                    t.month = MON_MAX;
                t.year = t.year - 14'd1;
            end
            fit_day(t);
            return 1'b0;
        end
        if (kind == REQ_DN_SEC)
        begin
            if (t.seconds > 6'd0)
            begin
                t.seconds = t.seconds - 6'd1;
                borrow = 1'b0;
            end
            else
                t.seconds = SEC_MAX;
        end
        if (borrow && kind <= REQ_DN_MIN)
        begin
            if (t.minutes > 6'd0)
            begin
                t.minutes = t.minutes - 6'd1;
                borrow = 1'b0;
            end
            else
                t.minutes = MIN_MAX;
        end
        if (borrow && kind <= REQ_DN_HOUR)
        begin
            if (t.hours > 5'd0)
            begin
                t.hours = t.hours - 5'd1;
                borrow = 1'b0;
            end
            else
                t.hours = HOUR_MAX;
        end
        if (borrow && kind <= REQ_DN_DAY)
        begin
            if (t.day > DAY_MIN)
                t.day = t.day - 5'd1;
            else
            begin
                if (t.month > MON_MIN)
                    t.month = t.month - 4'd1;
                else if (t.year <= YEAR_MIN)
                    return 1'b1;
                else
                begin
                    t.month = MON_MAX;
                    t.year = t.year - 14'd1;
                end
                t.day = days_of(t.month, t.year);
            end
        end
        return 1'b0;
    endfunction

    function automatic bit load_ok(input ccs_time_t ld);
        return ld.month >= MON_MIN && ld.month <= MON_MAX &&
               ld.year >= YEAR_MIN && ld.year <= YEAR_MAX &&
               ld.day >= DAY_MIN && ld.day <= days_of(ld.month, ld.year) &&
               ld.hours <= HOUR_MAX && ld.minutes <= MIN_MAX && ld.seconds <= SEC_MAX;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [13:0] got,
                               input logic [13:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic predict_request(input logic [3:0] kind, input ccs_time_t ld);
        ccs_time_t trial;
        outcome_t  o;
        bit        hit_limit;
        trial     = clock_now;
        hit_limit = 1'b0;
        o.status  = ST_DONE;
        if (kind <= REQ_UP_YEAR)
            hit_limit = step_up(trial, kind);
        else if (kind <= REQ_DN_YEAR)
            hit_limit = step_down(trial, kind);
        else if (kind == REQ_LOAD)
        begin
            if (load_ok(ld))
                trial = ld;
            else
                o.status = ST_REJECT;
        end
        if (hit_limit)
            o.status = ST_SAT;
        if (o.status == ST_DONE)
            clock_now = trial;
        o.moment = clock_now;
        outcome_q.push_back(o);
    endtask

    task automatic compare_result;
        outcome_t  want;
        ccs_time_t got;
        if (outcome_q.size() == 0)
        begin
            flag_mismatch("result beat with no request waiting");
            return;
        end
        want = outcome_q.pop_front();
        got  = m_tdata;
        check_field("day", 14'(got.day), 14'(want.moment.day));
        check_field("month", 14'(got.month), 14'(want.moment.month));
        check_field("year", got.year, want.moment.year);
        check_field("hours", 14'(got.hours), 14'(want.moment.hours));
        check_field("minutes", 14'(got.minutes), 14'(want.moment.minutes));
        check_field("seconds", 14'(got.seconds), 14'(want.moment.seconds));
        check_field("status", 14'(m_tuser), 14'(want.status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_now.day     = DAY_MIN;
            clock_now.month   = MON_MIN;
            clock_now.year    = 14'd1000;
            clock_now.hours   = '0;
            clock_now.minutes = '0;
            clock_now.seconds = '0;
            outcome_q.delete();
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                compare_result();
            pending <= outcome_q.size();
        end
    end

endmodule

/* dv/calendar_clock_stepper_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// calendar_clock_stepper_tb
// Drives directed and random load, step and unused-code requests into the
// calendar clock stepper with random gaps and receiver stalls, one long
// receiver hold-off, and gives the verdict from the checker's mismatch count.
// ============================================================================
module calendar_clock_stepper_tb;
    import ccs_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 250;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int mismatches;
    int pending;
    int items_sent;
    int cycles;
    bit calm;

    calendar_clock_stepper u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    calendar_clock_stepper_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial
    begin
        bit held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && items_sent >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    function automatic ccs_time_t moment(input int y, input int mo, input int d,
                                         input int h, input int mi, input int s);
        moment.year    = 14'(y);
        moment.month   = 4'(mo);
        moment.day     = 5'(d);
        moment.hours   = 5'(h);
        moment.minutes = 6'(mi);
        moment.seconds = 6'(s);
    endfunction

    task automatic push_req(input logic [3:0] kind, input logic [39:0] load);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= load;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (!calm && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    initial
    begin
        ccs_time_t ld;
        int        pick;
        int        year_picks [8] = '{1, 2, 1900, 2000, 2100, 2400, 9998, 9999};
        items_sent = 0;
        calm       = 1'b0;
        wait (rst_n);
        @(posedge clk);

        // upper limit on every unit
        push_req(REQ_LOAD, moment(9999, 12, 31, 23, 59, 59));
        for (int k = REQ_UP_SEC; k <= REQ_UP_YEAR; k++)
            push_req(4'(k), 40'({$urandom, $urandom}));
        // lower limit on every unit
        push_req(REQ_LOAD, moment(1, 1, 1, 0, 0, 0));
        for (int k = REQ_DN_SEC; k <= REQ_DN_YEAR; k++)
            push_req(4'(k), 40'({$urandom, $urandom}));
        // unused request codes
        for (int k = REQ_LOAD + 1; k < 16; k++)
            push_req(4'(k), '1);
        // rejected loads: field extremes and a non-leap century
        push_req(REQ_LOAD, moment(0, 0, 0, 31, 63, 63));
        push_req(REQ_LOAD, moment(9999, 15, 31, 0, 0, 0));
        push_req(REQ_LOAD, moment(1900, 2, 29, 12, 0, 0));
        // leap day then clamp on year step
        push_req(REQ_LOAD, moment(2000, 2, 29, 0, 0, 0));
        push_req(REQ_UP_YEAR, '0);
        // january borrow through every unit
        push_req(REQ_LOAD, moment(2001, 1, 1, 0, 0, 0));
        push_req(REQ_DN_SEC, '0);
        // clamp on month step into a non-leap century february
        push_req(REQ_LOAD, moment(2100, 1, 31, 6, 30, 30));
        push_req(REQ_UP_MON, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 600 && i < 850);
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                ld.year    = $urandom_range(0, 1) ? 14'(year_picks[$urandom_range(0, 7)])
                                                  : 14'($urandom_range(0, 9999));
                ld.month   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                         : 4'($urandom_range(1, 12));
                ld.day     = $urandom_range(0, 1) ? 5'($urandom_range(28, 31))
                                                  : 5'($urandom_range(1, 31));
                ld.hours   = ($urandom_range(0, 2) == 0) ? HOUR_MAX
                           : 5'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 31 : 23));
                ld.minutes = ($urandom_range(0, 2) == 0) ? MIN_MAX
                           : 6'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 63 : 59));
                ld.seconds = ($urandom_range(0, 2) == 0) ? SEC_MAX
                           : 6'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 63 : 59));
                push_req(REQ_LOAD, ld);
            end
            else if (pick < 19)
                push_req(4'($urandom_range(REQ_LOAD + 1, 15)), 40'({$urandom, $urandom}));
            else
                push_req(4'($urandom_range(REQ_UP_SEC, REQ_DN_YEAR)),
                         40'({$urandom, $urandom}));
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
